// ----- design/mau_pkg.sv -----
// Shared types and constants of the 256-bit modular arithmetic unit.
// No dependencies; every other file of the unit uses this package.
package mau_pkg;

  localparam int LIMB_W     = 64;
  localparam int LIMB_COUNT = 4;
  localparam int WORD_W     = LIMB_W * LIMB_COUNT;
  localparam int PROD_W     = 2 * WORD_W;
  localparam int CNT_W      = 10;
  localparam int OCNT_W     = 4;

  localparam logic [WORD_W-1:0] WORD_ONE   = WORD_W'(1);
  localparam logic [CNT_W-1:0]  STEPS_LONG = CNT_W'(PROD_W);
  localparam logic [CNT_W-1:0]  STEPS_SHORT = CNT_W'(WORD_W);
  localparam logic [OCNT_W-1:0] LIMBS_NARROW = OCNT_W'(LIMB_COUNT);
  localparam logic [OCNT_W-1:0] LIMBS_WIDE   = OCNT_W'(2 * LIMB_COUNT);

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_EXEC = 1'b1;
  localparam logic [3:0] OP_LAST_CODE = 4'd9;

  typedef enum logic [3:0] {
    OP_ADDMOD  = 4'd0,
    OP_SUBMOD  = 4'd1,
    OP_MULMOD  = 4'd2,
    OP_POWMOD  = 4'd3,
    OP_INVMOD  = 4'd4,
    OP_DIVMOD  = 4'd5,
    OP_GCD     = 4'd6,
    OP_MULWIDE = 4'd7,
    OP_ADD     = 4'd8,
    OP_SUB     = 4'd9
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOINV   = 2'd1,
    ST_DIVZERO = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_MUL,
    S_DIV,
    S_SUBM_B,
    S_SUB,
    S_FIX,
    S_INV_ROT,
    S_POW_CHECK,
    S_POW_SQ,
    S_INV_CHECK,
    S_INV_MUL,
    S_GCD_CHECK,
    S_RESULT
  } ctrl_state_e;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_INIT,
    CMD_DIVLOAD,
    CMD_DIVSTEP,
    CMD_MULLOAD,
    CMD_MULSTEP,
    CMD_R_TO_X,
    CMD_R_TO_Y,
    CMD_POW_SQ_DONE,
    CMD_EUCLID,
    CMD_SUB,
    CMD_FIX,
    CMD_INV_ROT,
    CMD_WRAP,
    CMD_RESULT
  } dp_cmd_e;

  typedef enum logic [2:0] {
    NUM_SUM,
    NUM_A,
    NUM_B,
    NUM_X,
    NUM_P
  } num_sel_e;

  typedef enum logic [1:0] {
    DEN_M,
    DEN_B,
    DEN_Y
  } den_sel_e;

  typedef enum logic [1:0] {
    MA_A,
    MA_X,
    MA_Y,
    MA_Q
  } ma_sel_e;

  typedef enum logic [1:0] {
    MB_B,
    MB_Y,
    MB_S2
  } mb_sel_e;

  typedef enum logic {
    SUB_XY,
    SUB_S1R
  } sub_sel_e;

  typedef struct packed {
    dp_cmd_e  cmd;
    op_e      op;
    num_sel_e num;
    den_sel_e den;
    ma_sel_e  ma;
    mb_sel_e  mb;
    sub_sel_e subsel;
    status_e  status;
    logic     zero;
  } dp_cmd_t;

  typedef struct packed {
    logic m_zero;
    logic m_one;
    logic b_zero;
    logic e_zero;
    logic e_lsb;
    logic y_zero;
    logic x_one;
    logic cnt_done;
    logic out_busy;
  } dp_sts_t;

endpackage

// ----- design/mau_if.sv -----
// Item channel interfaces of the modular arithmetic unit.
// Depends on mau_pkg for the field widths.
interface mau_in_if;
  logic                     valid;
  logic                     ready;
  logic                     kind;
  logic                     operand_select;
  logic [1:0]               limb_index;
  logic [mau_pkg::LIMB_W-1:0] limb_value;
  logic [3:0]               operation;

  modport source (output valid, kind, operand_select, limb_index, limb_value, operation,
                  input ready);
  modport sink (input valid, kind, operand_select, limb_index, limb_value, operation,
                output ready);
endinterface

interface mau_out_if;
  logic                     valid;
  logic                     ready;
  logic [mau_pkg::LIMB_W-1:0] result_limb;
  logic [2:0]               result_index;
  logic                     last;
  logic [1:0]               status;

  modport source (output valid, result_limb, result_index, last, status, input ready);
  modport sink (input valid, result_limb, result_index, last, status, output ready);
endinterface

// ----- design/mau_ctrl.sv -----
// Sequencing state machine of the modular arithmetic unit.
// Depends on mau_pkg; drives the datapath through dp_cmd_t and reads dp_sts_t.
module mau_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_kind_i,
  input  logic [3:0]        in_operation_i,
  output logic              in_ready_o,
  input  mau_pkg::dp_sts_t  sts_i,
  output mau_pkg::dp_cmd_t  cmd_o
);
  import mau_pkg::*;

  ctrl_state_e state_q, state_d;
  op_e         op_q, op_d;
  logic        phase_q, phase_d;
  status_e     status_q, status_d;
  logic        zero_q, zero_d;
  logic        mod_op;

  // Operations that need a nonzero modulus.
  assign mod_op = (op_q == OP_ADDMOD) || (op_q == OP_SUBMOD) || (op_q == OP_MULMOD) ||
                  (op_q == OP_POWMOD) || (op_q == OP_INVMOD);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      op_q     <= OP_ADDMOD;
      phase_q  <= 1'b0;
      status_q <= ST_OK;
      zero_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      op_q     <= op_d;
      phase_q  <= phase_d;
      status_q <= status_d;
      zero_q   <= zero_d;
    end
  end

  // Next state.
  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    phase_d  = phase_q;
    status_d = status_q;
    zero_d   = zero_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i && (in_kind_i == KIND_EXEC) && (in_operation_i <= OP_LAST_CODE)) begin
          op_d     = op_e'(in_operation_i);
          status_d = ST_OK;
          zero_d   = 1'b0;
          phase_d  = 1'b0;
          state_d  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (mod_op && sts_i.m_zero) begin
          status_d = ST_DIVZERO;
          zero_d   = 1'b1;
          state_d  = S_RESULT;
        end else begin
          case (op_q)
            OP_ADDMOD, OP_SUBMOD: state_d = S_DIV;
            OP_MULMOD, OP_MULWIDE: state_d = S_MUL;
            OP_POWMOD: begin
              if (sts_i.m_one) begin
                zero_d  = 1'b1;
                state_d = S_RESULT;
              end else begin
                state_d = S_POW_CHECK;
              end
            end
            OP_INVMOD: begin
              if (sts_i.m_one) begin
                zero_d  = 1'b1;
                state_d = S_RESULT;
              end else begin
                state_d = S_INV_CHECK;
              end
            end
            OP_DIVMOD: begin
              if (sts_i.b_zero) begin
                status_d = ST_DIVZERO;
                zero_d   = 1'b1;
                state_d  = S_RESULT;
              end else begin
                state_d = S_DIV;
              end
            end
            OP_GCD: state_d = S_GCD_CHECK;
            default: state_d = S_RESULT;
          endcase
        end
      end
      S_MUL: begin
        if (sts_i.cnt_done) begin
          state_d = (op_q == OP_MULWIDE) ? S_RESULT : S_DIV;
        end
      end
      S_DIV: begin
        if (sts_i.cnt_done) begin
          case (op_q)
            OP_SUBMOD: state_d = phase_q ? S_SUB : S_SUBM_B;
            OP_POWMOD: state_d = phase_q ? S_POW_CHECK : S_POW_SQ;
            OP_INVMOD: state_d = phase_q ? S_SUB : S_INV_MUL;
            OP_GCD:    state_d = S_GCD_CHECK;
            default:   state_d = S_RESULT;
          endcase
        end
      end
      S_SUBM_B: begin
        phase_d = 1'b1;
        state_d = S_DIV;
      end
      S_SUB: state_d = S_FIX;
      S_FIX: state_d = (op_q == OP_SUBMOD) ? S_RESULT : S_INV_ROT;
      S_INV_ROT: state_d = S_INV_CHECK;
      S_POW_CHECK: begin
        if (sts_i.e_zero) begin
          state_d = S_RESULT;
        end else if (sts_i.e_lsb) begin
          phase_d = 1'b0;
          state_d = S_MUL;
        end else begin
          state_d = S_POW_SQ;
        end
      end
      S_POW_SQ: begin
        phase_d = 1'b1;
        state_d = S_MUL;
      end
      S_INV_CHECK: begin
        if (sts_i.y_zero) begin
          status_d = sts_i.x_one ? ST_OK : ST_NOINV;
          zero_d   = !sts_i.x_one;
          state_d  = S_RESULT;
        end else begin
          phase_d = 1'b0;
          state_d = S_DIV;
        end
      end
      S_INV_MUL: begin
        phase_d = 1'b1;
        state_d = S_MUL;
      end
      S_GCD_CHECK: state_d = sts_i.y_zero ? S_RESULT : S_DIV;
      S_RESULT: begin
        if (!sts_i.out_busy) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    in_ready_o    = 1'b0;
    cmd_o.cmd     = CMD_NONE;
    cmd_o.op      = op_q;
    cmd_o.num     = NUM_P;
    cmd_o.den     = DEN_M;
    cmd_o.ma      = MA_A;
    cmd_o.mb      = MB_B;
    cmd_o.subsel  = (op_q == OP_SUBMOD) ? SUB_XY : SUB_S1R;
    cmd_o.status  = status_q;
    cmd_o.zero    = zero_q;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i && (in_kind_i == KIND_LOAD)) begin
          cmd_o.cmd = CMD_LOAD;
        end
      end
      S_DISPATCH: begin
        if (!(mod_op && sts_i.m_zero)) begin
          case (op_q)
            OP_ADDMOD: begin
              cmd_o.cmd = CMD_DIVLOAD;
              cmd_o.num = NUM_SUM;
            end
            OP_SUBMOD: begin
              cmd_o.cmd = CMD_DIVLOAD;
              cmd_o.num = NUM_A;
            end
            OP_MULMOD, OP_MULWIDE: cmd_o.cmd = CMD_MULLOAD;
            OP_POWMOD, OP_INVMOD: begin
              if (!sts_i.m_one) begin
                cmd_o.cmd = CMD_INIT;
              end
            end
            OP_DIVMOD: begin
              if (!sts_i.b_zero) begin
                cmd_o.cmd = CMD_DIVLOAD;
                cmd_o.num = NUM_A;
                cmd_o.den = DEN_B;
              end
            end
            OP_GCD: cmd_o.cmd = CMD_INIT;
            default: cmd_o.cmd = CMD_WRAP;
          endcase
        end
      end
      S_MUL: begin
        if (!sts_i.cnt_done) begin
          cmd_o.cmd = CMD_MULSTEP;
        end else if (op_q != OP_MULWIDE) begin
          cmd_o.cmd = CMD_DIVLOAD;
        end
      end
      S_DIV: begin
        if (!sts_i.cnt_done) begin
          cmd_o.cmd = CMD_DIVSTEP;
        end else begin
          case (op_q)
            OP_SUBMOD: cmd_o.cmd = phase_q ? CMD_R_TO_Y : CMD_R_TO_X;
            OP_POWMOD: cmd_o.cmd = phase_q ? CMD_POW_SQ_DONE : CMD_R_TO_X;
            OP_INVMOD: cmd_o.cmd = phase_q ? CMD_NONE : CMD_EUCLID;
            OP_GCD:    cmd_o.cmd = CMD_EUCLID;
            default:   cmd_o.cmd = CMD_NONE;
          endcase
        end
      end
      S_SUBM_B: begin
        cmd_o.cmd = CMD_DIVLOAD;
        cmd_o.num = NUM_B;
      end
      S_SUB:     cmd_o.cmd = CMD_SUB;
      S_FIX:     cmd_o.cmd = CMD_FIX;
      S_INV_ROT: cmd_o.cmd = CMD_INV_ROT;
      S_POW_CHECK: begin
        if (!sts_i.e_zero && sts_i.e_lsb) begin
          cmd_o.cmd = CMD_MULLOAD;
          cmd_o.ma  = MA_X;
          cmd_o.mb  = MB_Y;
        end
      end
      S_POW_SQ: begin
        cmd_o.cmd = CMD_MULLOAD;
        cmd_o.ma  = MA_Y;
        cmd_o.mb  = MB_Y;
      end
      S_INV_CHECK, S_GCD_CHECK: begin
        if (!sts_i.y_zero) begin
          cmd_o.cmd = CMD_DIVLOAD;
          cmd_o.num = NUM_X;
          cmd_o.den = DEN_Y;
        end
      end
      S_INV_MUL: begin
        cmd_o.cmd = CMD_MULLOAD;
        cmd_o.ma  = MA_Q;
        cmd_o.mb  = MB_S2;
      end
      S_RESULT: begin
        if (!sts_i.out_busy) begin
          cmd_o.cmd = CMD_RESULT;
        end
      end
      default: cmd_o.cmd = CMD_NONE;
    endcase
  end

endmodule

// ----- design/mau_datapath.sv -----
// Operand, work and result registers of the modular arithmetic unit, with the
// shift-add multiplier, shift-subtract divider and result streamer. Uses mau_pkg.
module mau_datapath (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  mau_pkg::dp_cmd_t          cmd_i,
  input  logic                      operand_select_i,
  input  logic [1:0]                limb_index_i,
  input  logic [mau_pkg::LIMB_W-1:0] limb_value_i,
  input  logic                      cfg_we_i,
  input  logic [1:0]                cfg_idx_i,
  input  logic [mau_pkg::LIMB_W-1:0] cfg_data_i,
  output mau_pkg::dp_sts_t          sts_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [mau_pkg::LIMB_W-1:0] result_limb_o,
  output logic [2:0]                result_index_o,
  output logic                      last_o,
  output logic [1:0]                status_o
);
  import mau_pkg::*;

  logic [WORD_W-1:0] a_q, b_q, m_q;
  logic [WORD_W-1:0] x_q, y_q, s1_q, s2_q, e_q, t_q, d_q, r_q, q_q, ma_q, mb_q;
  logic [PROD_W-1:0] p_q, ob_q;
  logic              lt_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [OCNT_W-1:0] oc_q;
  logic [2:0]        idx_q;
  status_e           ost_q;

  logic [WORD_W:0]   sum_ab;
  logic [WORD_W:0]   div_sh;
  logic [WORD_W+1:0] div_diff;
  logic              div_ge;
  logic [PROD_W-1:0] mul_add;
  logic [WORD_W-1:0] sub_l, sub_r;
  logic [WORD_W:0]   sub_res;
  logic [WORD_W-1:0] fix_res, wrap_res;
  logic [PROD_W-1:0] res_sel;
  logic              out_fire;

  assign sum_ab   = {1'b0, a_q} + {1'b0, b_q};
  assign div_sh   = {r_q, p_q[PROD_W-1]};
  assign div_diff = {1'b0, div_sh} - {2'b00, d_q};
  assign div_ge   = !div_diff[WORD_W+1];
  assign mul_add  = {p_q[PROD_W-2:0], 1'b0} +
                    (mb_q[WORD_W-1] ? {{WORD_W{1'b0}}, ma_q} : {PROD_W{1'b0}});
  assign sub_l    = (cmd_i.subsel == SUB_XY) ? x_q : s1_q;
  assign sub_r    = (cmd_i.subsel == SUB_XY) ? y_q : r_q;
  assign sub_res  = {1'b0, sub_l} - {1'b0, sub_r};
  assign fix_res  = t_q + (lt_q ? m_q : {WORD_W{1'b0}});
  assign wrap_res = (cmd_i.op == OP_ADD) ? (a_q + b_q) : (a_q - b_q);

  always_comb begin
    if (cmd_i.zero) begin
      res_sel = '0;
    end else begin
      case (cmd_i.op)
        OP_ADDMOD, OP_MULMOD:       res_sel = {{WORD_W{1'b0}}, r_q};
        OP_SUBMOD, OP_ADD, OP_SUB:  res_sel = {{WORD_W{1'b0}}, t_q};
        OP_POWMOD, OP_GCD:          res_sel = {{WORD_W{1'b0}}, x_q};
        OP_INVMOD:                  res_sel = {{WORD_W{1'b0}}, s1_q};
        OP_DIVMOD:                  res_sel = {r_q, q_q};
        OP_MULWIDE:                 res_sel = p_q;
        default:                    res_sel = '0;
      endcase
    end
  end

  // Operands and modulus, cleared at reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q <= '0;
      b_q <= '0;
      m_q <= '0;
    end else begin
      if (cfg_we_i) begin
        m_q[cfg_idx_i*LIMB_W +: LIMB_W] <= cfg_data_i;
      end
      if (cmd_i.cmd == CMD_LOAD) begin
        if (operand_select_i) begin
          b_q[limb_index_i*LIMB_W +: LIMB_W] <= limb_value_i;
        end else begin
          a_q[limb_index_i*LIMB_W +: LIMB_W] <= limb_value_i;
        end
      end
    end
  end

  // Work registers; each is written before an operation reads it.
  always_ff @(posedge clk_i) begin
    case (cmd_i.cmd)
      CMD_INIT: begin
        x_q  <= (cmd_i.op == OP_POWMOD) ? WORD_ONE : a_q;
        y_q  <= (cmd_i.op == OP_POWMOD) ? a_q : ((cmd_i.op == OP_INVMOD) ? m_q : b_q);
        s1_q <= WORD_ONE;
        s2_q <= '0;
        e_q  <= b_q;
      end
      CMD_DIVLOAD: begin
        case (cmd_i.num)
          NUM_SUM: p_q <= {{(PROD_W-WORD_W-1){1'b0}}, sum_ab};
          NUM_A:   p_q <= {a_q, {WORD_W{1'b0}}};
          NUM_B:   p_q <= {b_q, {WORD_W{1'b0}}};
          NUM_X:   p_q <= {x_q, {WORD_W{1'b0}}};
          default: p_q <= p_q;
        endcase
        case (cmd_i.den)
          DEN_B:   d_q <= b_q;
          DEN_Y:   d_q <= y_q;
          default: d_q <= m_q;
        endcase
        r_q <= '0;
        q_q <= '0;
      end
      CMD_DIVSTEP: begin
        r_q <= div_ge ? div_diff[WORD_W-1:0] : div_sh[WORD_W-1:0];
        q_q <= {q_q[WORD_W-2:0], div_ge};
        p_q <= {p_q[PROD_W-2:0], 1'b0};
      end
      CMD_MULLOAD: begin
        case (cmd_i.ma)
          MA_X:    ma_q <= x_q;
          MA_Y:    ma_q <= y_q;
          MA_Q:    ma_q <= q_q;
          default: ma_q <= a_q;
        endcase
        case (cmd_i.mb)
          MB_Y:    mb_q <= y_q;
          MB_S2:   mb_q <= s2_q;
          default: mb_q <= b_q;
        endcase
        p_q <= '0;
      end
      CMD_MULSTEP: begin
        p_q  <= mul_add;
        mb_q <= {mb_q[WORD_W-2:0], 1'b0};
      end
      CMD_R_TO_X: x_q <= r_q;
      CMD_R_TO_Y: y_q <= r_q;
      CMD_POW_SQ_DONE: begin
        y_q <= r_q;
        e_q <= {1'b0, e_q[WORD_W-1:1]};
      end
      CMD_EUCLID: begin
        x_q <= y_q;
        y_q <= r_q;
      end
      CMD_SUB: begin
        t_q  <= sub_res[WORD_W-1:0];
        lt_q <= sub_res[WORD_W];
      end
      CMD_FIX: t_q <= fix_res;
      CMD_INV_ROT: begin
        s1_q <= s2_q;
        s2_q <= t_q;
      end
      CMD_WRAP: t_q <= wrap_res;
      default: ;
    endcase
  end

  // Step counter shared by the multiplier and the divider.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      case (cmd_i.cmd)
        CMD_DIVLOAD: cnt_q <= ((cmd_i.num == NUM_SUM) || (cmd_i.num == NUM_P)) ?
                              STEPS_LONG : STEPS_SHORT;
        CMD_MULLOAD: cnt_q <= STEPS_SHORT;
        CMD_DIVSTEP, CMD_MULSTEP: cnt_q <= cnt_q - CNT_W'(1);
        default: ;
      endcase
    end
  end

  // Result streamer: holds one finished result while the core moves on.
  assign out_fire = (oc_q != '0) && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oc_q  <= '0;
      idx_q <= '0;
      ost_q <= ST_OK;
    end else if (cmd_i.cmd == CMD_RESULT) begin
      oc_q  <= ((cmd_i.op == OP_DIVMOD) || (cmd_i.op == OP_MULWIDE)) ? LIMBS_WIDE : LIMBS_NARROW;
      idx_q <= '0;
      ost_q <= cmd_i.status;
    end else if (out_fire) begin
      oc_q  <= oc_q - OCNT_W'(1);
      idx_q <= idx_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cmd == CMD_RESULT) begin
      ob_q <= res_sel;
    end else if (out_fire) begin
      ob_q <= {{LIMB_W{1'b0}}, ob_q[PROD_W-1:LIMB_W]};
    end
  end

  assign out_valid_o    = (oc_q != '0);
  assign result_limb_o  = ob_q[LIMB_W-1:0];
  assign result_index_o = idx_q;
  assign last_o         = (oc_q == OCNT_W'(1));
  assign status_o       = ost_q;

  assign sts_o.m_zero   = (m_q == '0);
  assign sts_o.m_one    = (m_q == WORD_ONE);
  assign sts_o.b_zero   = (b_q == '0);
  assign sts_o.e_zero   = (e_q == '0);
  assign sts_o.e_lsb    = e_q[0];
  assign sts_o.y_zero   = (y_q == '0);
  assign sts_o.x_one    = (x_q == WORD_ONE);
  assign sts_o.cnt_done = (cnt_q == '0);
  assign sts_o.out_busy = (oc_q != '0);

  // The streamer never holds more limbs than the widest result.
  a_oc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    oc_q <= LIMBS_WIDE)
    else $error("result limb count out of range");

  // A step is only ever issued while the counter still has steps left.
  a_step_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.cmd == CMD_DIVSTEP || cmd_i.cmd == CMD_MULSTEP) |-> cnt_q != '0)
    else $error("arithmetic step issued past the end of its count");

  // A new result is never loaded over one that is still streaming.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.cmd == CMD_RESULT) |-> oc_q == '0)
    else $error("result loaded while the previous one is still streaming");

endmodule

// ----- design/modular_arithmetic_unit_256.sv -----
// A load item is written into the operands as it is taken. Of the execute items, add and sub
// need no multiply or divide steps, submod takes one 256-step reduction per operand and powmod
// takes, per exponent bit, up to two 256-step multiplies, each followed by a 512-step reduction.
// Execute items are taken one at a time, as the controller accepts items only while idle; the
// bit-serial multiplier and divider set how long each one runs. Reset: operands and modulus
// clear at once.
module modular_arithmetic_unit_256 (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  mau_in_if.sink                    in_if,
  mau_out_if.source                 out_if,
  input  logic                      cfg_we_i,
  input  logic [1:0]                cfg_idx_i,
  input  logic [mau_pkg::LIMB_W-1:0] cfg_data_i
);
  import mau_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    in_ready;

  // The controller accepts items only when idle; a finished result sits in the
  // datapath's streamer, so the next item may be taken while it drains.
  assign in_if.ready = in_ready;

  mau_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_if.valid),
    .in_kind_i      (in_if.kind),
    .in_operation_i (in_if.operation),
    .in_ready_o     (in_ready),
    .sts_i          (sts),
    .cmd_o          (cmd)
  );

  // The datapath holds operands, modulus, work registers and the result
  // streamer. Operand loads are taken on the controller's load command.
  mau_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .operand_select_i (in_if.operand_select),
    .limb_index_i     (in_if.limb_index),
    .limb_value_i     (in_if.limb_value),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .sts_o            (sts),
    .out_valid_o      (out_if.valid),
    .out_ready_i      (out_if.ready),
    .result_limb_o    (out_if.result_limb),
    .result_index_o   (out_if.result_index),
    .last_o           (out_if.last),
    .status_o         (out_if.status)
  );

endmodule
